// ===== design/mseu_pkg.sv =====
// Shared types and constants for the MIPS subset execute unit.
// No dependencies; every other file in design/ except mseu_ram refers to this package by scoped names.
package mseu_pkg;

  localparam logic [31:0] RESET_PC    = 32'h0040_0000;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          REG_COUNT   = 32;
  localparam int          REG_AW      = 5;

  // Primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;

  // R-type function codes
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0   = 5'd4;

  // Syscall numbers found in v0
  localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
  localparam logic [31:0] SYS_EXIT       = 32'd10;
  localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PRINT_INT  = 3'd1,
    EV_EXIT       = 3'd2,
    EV_PRINT_CHAR = 3'd3,
    EV_ERROR      = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_SLT,
    OP_ADDI,
    OP_BNE,
    OP_TRAP,
    OP_ERROR
  } op_t;

  // Decoded instruction handed from the front end to the back end
  typedef struct packed {
    op_t               op;
    logic [REG_AW-1:0] ra;    // first read port address
    logic [REG_AW-1:0] rb;    // second read port address
    logic [REG_AW-1:0] wa;    // destination register
    logic              wen;   // destination write (never to register zero)
    logic [31:0]       imm;   // sign-extended immediate, or branch offset plus 4
  } item_t;

endpackage

// ===== design/mips_subset_execute_unit.sv =====
// Top level of the MIPS subset execute unit: front end, item queue, back end.
// Depends on mseu_pkg, mseu_front, mseu_queue, mseu_exec (and mseu_ram below it).
//
//  channel   group            fields (lowest bit first)
//  -------   --------------   ------------------------------------------------
//  input     s_axis_*         tdata: instruction[31:0]
//  output    m_axis_*         tdata: next_pc[31:0], event_res[34:32],
//                                    event_value[66:35], halted[67], zero[71:68]
//  config    cfg_wen/wdata    start_pc (also loads the program counter)
//
// Sustains one item per cycle while m_axis is ready; a result passes through the
// decode register, queue, register file read and result register before m_axis.
// The register file read is registered, so the last write is forwarded from a
// bypass register; that forwarding is what keeps dependent items back to back.
// Reset clears the register file through per-register valid bits at once, loads
// the PC with 0x00400000 and clears the stop flag; no clearing pass is needed.
// A stall on m_axis backs up through the queue; the front keeps accepting until
// the queue and its decode register are full.
module mips_subset_execute_unit #(
  parameter int QueueDepth = mseu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  // instruction items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // instruction[31:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // next_pc, event_res, event_value, halted
);

  logic            dec_valid;
  logic            dec_ready;
  mseu_pkg::item_t dec_item;
  logic            q_valid;
  logic            q_ready;
  mseu_pkg::item_t q_item;
  logic [31:0]     out_pc;
  mseu_pkg::ev_t   out_ev;
  logic [31:0]     out_val;
  logic            out_halted;

  // Decode one instruction word per cycle into an execute item while the queue has room
  mseu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .instruction (s_axis_tdata),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec_item    (dec_item)
  );

  // Decouple decode from execute so either side can stall alone
  mseu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_item  (dec_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Read operands, execute, write back, advance the PC and hold the result
  mseu_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pc     (out_pc),
    .out_ev     (out_ev),
    .out_val    (out_val),
    .out_halted (out_halted)
  );

  // Pack result fields, lowest field first, padded to whole bytes
  assign m_axis_tdata = {4'b0000, out_halted, out_val, out_ev, out_pc};

endmodule

// ===== design/mseu_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mseu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/mseu_front.sv =====
// Front end: accepts instruction words, decodes them into mseu_pkg::item_t and holds one.
// Depends on mseu_pkg.
module mseu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         instruction,
  output logic                dec_valid,
  input  logic                dec_ready,
  output mseu_pkg::item_t     dec_item
);

  logic            valid;
  mseu_pkg::item_t item;
  mseu_pkg::item_t item_next;

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] simm;

  assign opc  = instruction[31:26];
  assign rs   = instruction[25:21];
  assign rt   = instruction[20:16];
  assign rd   = instruction[15:11];
  assign fn   = instruction[5:0];
  assign simm = {{16{instruction[15]}}, instruction[15:0]};

  always_comb begin
    item_next.op  = mseu_pkg::OP_ERROR;
    item_next.ra  = rs;
    item_next.rb  = rt;
    item_next.wa  = rd;
    item_next.wen = 1'b0;
    item_next.imm = simm;
    unique case (opc)
      mseu_pkg::OPC_SPECIAL: begin
        unique case (fn)
          mseu_pkg::FN_ADD, mseu_pkg::FN_ADDU: begin
            item_next.op  = mseu_pkg::OP_ADD;
            item_next.wen = (rd != mseu_pkg::REG_ZERO);
          end
          mseu_pkg::FN_SUB, mseu_pkg::FN_SUBU: begin
            item_next.op  = mseu_pkg::OP_SUB;
            item_next.wen = (rd != mseu_pkg::REG_ZERO);
          end
          mseu_pkg::FN_SLT: begin
            item_next.op  = mseu_pkg::OP_SLT;
            item_next.wen = (rd != mseu_pkg::REG_ZERO);
          end
          mseu_pkg::FN_SYSCALL: begin
            // read v0 and a0 through the normal operand ports
            item_next.op = mseu_pkg::OP_TRAP;
            item_next.ra = mseu_pkg::REG_V0;
            item_next.rb = mseu_pkg::REG_A0;
          end
          default: item_next.op = mseu_pkg::OP_ERROR;
        endcase
      end
      mseu_pkg::OPC_ADDI, mseu_pkg::OPC_ADDIU: begin
        item_next.op  = mseu_pkg::OP_ADDI;
        item_next.wa  = rt;
        item_next.wen = (rt != mseu_pkg::REG_ZERO);
      end
      mseu_pkg::OPC_BNE: begin
        // fold the sequential step into the taken offset
        item_next.op  = mseu_pkg::OP_BNE;
        item_next.imm = {simm[29:0], 2'b00} + mseu_pkg::PC_STEP;
      end
      default: item_next.op = mseu_pkg::OP_ERROR;
    endcase
  end

  assign in_ready  = !valid || dec_ready;
  assign dec_valid = valid;
  assign dec_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (dec_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== design/mseu_queue.sv =====
// Short FIFO of decoded items between the front and back ends.
// Depends on mseu_pkg.
module mseu_queue #(
  parameter int Depth = mseu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mseu_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mseu_pkg::item_t pop_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mseu_pkg::item_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/mseu_exec.sv =====
// Back end: register file read, execute, write back, PC and result register.
// Depends on mseu_pkg and mseu_ram.
module mseu_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [31:0]     cfg_wdata,
  input  logic            q_valid,
  output logic            q_ready,
  input  mseu_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_pc,
  output mseu_pkg::ev_t   out_ev,
  output logic [31:0]     out_val,
  output logic            out_halted
);

  logic                          ex_valid;
  mseu_pkg::item_t               ex_item;
  logic                          ex_fire;
  logic                          issue;
  logic [mseu_pkg::REG_COUNT-1:0] rf_vld;
  logic [31:0]                   ram_a;
  logic [31:0]                   ram_b;
  logic                          wb_valid;
  logic [mseu_pkg::REG_AW-1:0]   wb_addr;
  logic [31:0]                   wb_data;
  logic [31:0]                   opa;
  logic [31:0]                   opb;
  logic [31:0]                   pc;
  logic [31:0]                   pc_next;
  logic                          stopped;
  logic                          halt;
  logic                          rf_we;
  logic [31:0]                   rf_wdata;
  mseu_pkg::ev_t                 ev;
  logic [31:0]                   val;

  assign ex_fire = ex_valid && (!out_valid || out_ready);
  assign issue   = q_valid && (!ex_valid || ex_fire);
  assign q_ready = issue;

  mseu_ram #(
    .Width (32),
    .Depth (mseu_pkg::REG_COUNT)
  ) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (ex_item.wa),
    .wdata   (rf_wdata),
    .re      (issue),
    .raddr_a (q_item.ra),
    .raddr_b (q_item.rb),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // wb holds the most recent write, which the RAM may not yet show
  always_comb begin
    if (wb_valid && wb_addr == ex_item.ra) begin
      opa = wb_data;
    end else begin
      opa = rf_vld[ex_item.ra] ? ram_a : '0;
    end
    if (wb_valid && wb_addr == ex_item.rb) begin
      opb = wb_data;
    end else begin
      opb = rf_vld[ex_item.rb] ? ram_b : '0;
    end
  end

  always_comb begin
    ev       = mseu_pkg::EV_NONE;
    val      = '0;
    halt     = 1'b0;
    rf_wdata = opa + opb;
    pc_next  = pc;
    if (!stopped) begin
      unique case (ex_item.op)
        mseu_pkg::OP_ADD:  rf_wdata = opa + opb;
        mseu_pkg::OP_SUB:  rf_wdata = opa - opb;
        mseu_pkg::OP_SLT:  rf_wdata = {31'b0, ($signed(opa) < $signed(opb))};
        mseu_pkg::OP_ADDI: rf_wdata = opa + ex_item.imm;
        mseu_pkg::OP_BNE:  rf_wdata = opa + opb;
        mseu_pkg::OP_TRAP: begin
          priority if (opa == mseu_pkg::SYS_PRINT_INT) begin
            ev  = mseu_pkg::EV_PRINT_INT;
            val = opb;
          end else if (opa == mseu_pkg::SYS_PRINT_CHAR) begin
            ev  = mseu_pkg::EV_PRINT_CHAR;
            val = opb;
          end else if (opa == mseu_pkg::SYS_EXIT) begin
            ev   = mseu_pkg::EV_EXIT;
            val  = opb;
            halt = 1'b1;
          end else begin
            ev   = mseu_pkg::EV_ERROR;
            halt = 1'b1;
          end
        end
        default: begin
          ev   = mseu_pkg::EV_ERROR;
          halt = 1'b1;
        end
      endcase
      if (!halt) begin
        pc_next = pc + ((ex_item.op == mseu_pkg::OP_BNE && opa != opb) ?
                        ex_item.imm : mseu_pkg::PC_STEP);
      end
    end
  end

  assign rf_we = ex_fire && !stopped && ex_item.wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      rf_vld   <= '0;
      wb_valid <= 1'b0;
      pc       <= mseu_pkg::RESET_PC;
      stopped  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (rf_we) begin
        rf_vld[ex_item.wa] <= 1'b1;
        wb_valid           <= 1'b1;
      end
      if (cfg_wen) begin
        pc <= cfg_wdata;
      end else if (ex_fire) begin
        pc <= pc_next;
      end
      if (ex_fire && halt) begin
        stopped <= 1'b1;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ex_item <= q_item;
    end
    if (rf_we) begin
      wb_addr <= ex_item.wa;
      wb_data <= rf_wdata;
    end
    if (ex_fire) begin
      out_pc     <= pc_next;
      out_ev     <= ev;
      out_val    <= val;
      out_halted <= stopped || halt;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_ev == mseu_pkg::EV_ERROR || out_ev == mseu_pkg::EV_EXIT)
      |-> out_halted)
    else $error("exit or error result without halted");

  a_quiet_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_ev == mseu_pkg::EV_NONE || out_ev == mseu_pkg::EV_ERROR)
      |-> out_val == '0)
    else $error("nonzero value on a result with no syscall value");

  a_zero_reg: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> ex_item.wa != mseu_pkg::REG_ZERO)
    else $error("write to register zero");

endmodule
